[sv/dms_pkg.sv]
`timescale 1ns / 1ps

package dms_pkg;

    // Width of the removal countdown
    localparam int TIMER_WIDTH = 16;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int WAIT_WIDTH      = 16;
    localparam int ATTEMPT_WIDTH   = 5;

    localparam logic [ATTEMPT_WIDTH-1:0] ATTEMPT_SAT = '1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MAX_ATTEMPTS       = 3'd0,
        CFG_REMOVAL_WAIT_MS    = 3'd1,
        CFG_MOTOR_SPEED        = 3'd2,
        CFG_MANUAL_PRESENT     = 3'd3,
        CFG_SECOND_MAX_PRESENT = 3'd4
    } cfg_index_t;

    // Request kinds carried by an input beat
    typedef enum logic [1:0] {
        REQ_POLL     = 2'd0,
        REQ_DISPENSE = 2'd1,
        REQ_FORCED   = 2'd2,
        REQ_RESET    = 2'd3
    } req_kind_t;

    // Motor drive commands
    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_CW   = 2'd1,
        DRV_CCW  = 2'd2
    } drive_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DISPENSE = 3'd1,
        ST_RETURN   = 3'd2,
        ST_RECOVER  = 3'd3,
        ST_REMOVAL  = 3'd4,
        ST_ERROR    = 3'd5
    } state_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       min_limit;
        logic       max_limit;
        logic       max_limit_two;
        logic       empty_switch;
        logic       motor_blocked;
        logic       single_click;
        logic       long_press;
        logic       ms_tick;
    } req_t;

    typedef struct packed {
        logic [1:0]               motor_cmd;
        logic [7:0]               motor_speed_out;
        logic                     removal_led;
        logic [2:0]               state_code;
        logic [ATTEMPT_WIDTH-1:0] attempt_out;
        logic                     ready_res;
        logic                     empty_res;
        logic                     error_flag;
    } res_t;

    // Load value for the removal timer, saturated to the timer width
    function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [WAIT_WIDTH-1:0] wait_ms);
        logic [WAIT_WIDTH+TIMER_WIDTH-1:0] wide;
        logic [WAIT_WIDTH+TIMER_WIDTH-1:0] limit;
        wide  = (WAIT_WIDTH+TIMER_WIDTH)'(wait_ms);
        limit = (WAIT_WIDTH+TIMER_WIDTH)'({TIMER_WIDTH{1'b1}});
        if (wide > limit)
        begin
            timer_load = '1;
        end
        else
        begin
            timer_load = TIMER_WIDTH'(wide);
        end
    endfunction

endpackage

[sv/dispense_motor_sequencer_unit.sv]
`timescale 1ns / 1ps

// Dispensing motor sequencer.
// Input channel (req_valid / req_stall / req) carries one beat per poll step
// or request: poll, dispense, forced dispense or reset. Each accepted beat
// produces exactly one result beat on the output channel (res_valid /
// res_stall / res) with the motor command, LED, state and status flags.
// A beat's result is valid from the edge that accepts it. Throughput is one
// beat per cycle unless the receiver stalls; the whole state update is a
// single pass of combinational logic into the state and result registers.
// While the receiver stalls, the result register holds its beat and
// req_stall is raised, so no further beat is taken until it is drained. The
// configuration port (cfg_write / cfg_index / cfg_data) writes one register
// per edge; the user must use it only while the block is idle (not enforced).
// Reset clears the sequencer to idle with the motor stopped, LED off, the
// removal timer disarmed, the attempt count zero, the result register empty
// and the configuration at its defaults (3 attempts, 5000 ms, full speed,
// no manual switch, no second max switch).
module dispense_motor_sequencer_unit
    import dms_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  req_t                       req,
    output logic                       res_valid,
    input  logic                       res_stall,
    output res_t                       res
);

    // Configuration registers
    logic [3:0]            max_attempts_reg;
    logic [WAIT_WIDTH-1:0] removal_wait_reg;
    logic [7:0]            motor_speed_reg;
    logic                  manual_present_reg;
    logic                  second_max_reg;

    // Sequencer state
    state_t                   state_reg,   state_next;
    logic [ATTEMPT_WIDTH-1:0] attempt_reg, attempt_next;
    drive_t                   drive_reg,   drive_next;
    logic                     led_reg,     led_next;
    logic [TIMER_WIDTH-1:0]   timer_reg,   timer_next;
    logic                     armed_reg,   armed_next;

    // Result register
    logic res_valid_reg, res_valid_next;
    res_t res_reg,       res_next;

    logic req_fire;
    logic max_hit;

    assign req_stall = res_valid_reg & res_stall;
    assign req_fire  = req_valid & ~req_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign max_hit = req.max_limit | (second_max_reg & req.max_limit_two);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg   <= 4'd3;
            removal_wait_reg   <= WAIT_WIDTH'(5000);
            motor_speed_reg    <= 8'd255;
            manual_present_reg <= 1'b0;
            second_max_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_ATTEMPTS:       max_attempts_reg   <= cfg_data[3:0];
                CFG_REMOVAL_WAIT_MS:    removal_wait_reg   <= cfg_data[WAIT_WIDTH-1:0];
                CFG_MOTOR_SPEED:        motor_speed_reg    <= cfg_data[7:0];
                CFG_MANUAL_PRESENT:     manual_present_reg <= cfg_data[0];
                CFG_SECOND_MAX_PRESENT: second_max_reg     <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // Next state: on a poll, removal timer first, then one pass of the state machine
    always_comb
    begin
        state_next   = state_reg;
        attempt_next = attempt_reg;
        drive_next   = drive_reg;
        led_next     = led_reg;
        timer_next   = timer_reg;
        armed_next   = armed_reg;

        case (req_kind_t'(req.req_type))
            REQ_POLL:
            begin
                // Run the removal countdown
                if (armed_reg)
                begin
                    if (timer_reg == '0)
                    begin
                        led_next   = 1'b0;
                        state_next = ST_IDLE;
                        armed_next = 1'b0;
                    end
                    else if (req.ms_tick)
                    begin
                        timer_next = timer_reg - TIMER_WIDTH'(1);
                    end
                end

                case (state_next)
                    ST_ERROR:
                    begin
                        drive_next = DRV_STOP;
                    end
                    ST_RECOVER:
                    begin
                        if (!req.min_limit)
                        begin
                            drive_next = DRV_CCW;
                        end
                        else if (req.motor_blocked)
                        begin
                            drive_next = DRV_STOP;
                            state_next = ST_ERROR;
                        end
                        else
                        begin
                            drive_next = DRV_STOP;
                            if (attempt_reg != ATTEMPT_SAT)
                            begin
                                attempt_next = attempt_reg + ATTEMPT_WIDTH'(1);
                            end
                            if (attempt_next > ATTEMPT_WIDTH'(max_attempts_reg))
                            begin
                                state_next = ST_ERROR;
                            end
                            else
                            begin
                                state_next = ST_DISPENSE;
                            end
                        end
                    end
                    ST_DISPENSE:
                    begin
                        if (max_hit)
                        begin
                            drive_next = DRV_STOP;
                            state_next = ST_RETURN;
                        end
                        else if (req.motor_blocked)
                        begin
                            drive_next = DRV_STOP;
                            state_next = ST_RECOVER;
                        end
                        else
                        begin
                            drive_next = DRV_CW;
                        end
                    end
                    ST_RETURN:
                    begin
                        if (req.min_limit)
                        begin
                            drive_next = DRV_STOP;
                            state_next = ST_REMOVAL;
                        end
                        else if (req.motor_blocked)
                        begin
                            drive_next = DRV_STOP;
                            state_next = ST_ERROR;
                        end
                        else
                        begin
                            drive_next = DRV_CCW;
                        end
                    end
                    ST_REMOVAL:
                    begin
                        // Arm the timer once on entry
                        led_next = 1'b1;
                        if (!armed_next)
                        begin
                            timer_next = timer_load(removal_wait_reg);
                            armed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Idle: honour manual events, else home to the min switch
                        attempt_next = '0;
                        if (manual_present_reg && req.single_click)
                        begin
                            if (!req.empty_switch)
                            begin
                                attempt_next = ATTEMPT_WIDTH'(1);
                                state_next   = ST_DISPENSE;
                            end
                        end
                        else if (manual_present_reg && req.long_press)
                        begin
                            attempt_next = ATTEMPT_WIDTH'(1);
                            state_next   = ST_DISPENSE;
                        end
                        else
                        begin
                            drive_next = req.min_limit ? DRV_STOP : DRV_CCW;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            REQ_DISPENSE:
            begin
                if (state_reg == ST_IDLE && !req.empty_switch)
                begin
                    attempt_next = ATTEMPT_WIDTH'(1);
                    state_next   = ST_DISPENSE;
                end
            end
            REQ_FORCED:
            begin
                attempt_next = ATTEMPT_WIDTH'(1);
                state_next   = ST_DISPENSE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result beat from the updated state
    always_comb
    begin
        res_next.motor_cmd       = drive_next;
        res_next.motor_speed_out = (drive_next != DRV_STOP) ? motor_speed_reg : 8'd0;
        res_next.removal_led     = led_next;
        res_next.state_code      = state_next;
        res_next.attempt_out     = attempt_next;
        res_next.ready_res       = (state_next == ST_IDLE) && !req.empty_switch;
        res_next.empty_res       = req.empty_switch;
        res_next.error_flag      = (state_next == ST_ERROR);
    end

    // Hold the result until taken, refill on every accepted beat
    always_comb
    begin
        if (req_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Advance state on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            attempt_reg   <= '0;
            drive_reg     <= DRV_STOP;
            led_reg       <= 1'b0;
            timer_reg     <= '0;
            armed_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (req_fire)
            begin
                state_reg   <= state_next;
                attempt_reg <= attempt_next;
                drive_reg   <= drive_next;
                led_reg     <= led_next;
                timer_reg   <= timer_next;
                armed_reg   <= armed_next;
            end
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule
